// ----- hdl/pwh_pkg.sv -----
// ----------------------------------------------------------------------------
// pwh_pkg: shared types and constants of the window histogram unit
// Command codes, controller state, controller/datapath link structs and the
// fixed field widths of the stream and configuration ports.
// ----------------------------------------------------------------------------
package pwh_pkg;

	// field widths
	localparam int SAMPLE_W    = 16;
	localparam int BIN_W       = 8;
	localparam int PIX_W       = 8;
	localparam int COUNT_OUT_W = 32;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;

	// histogram geometry
	localparam int BIN_COUNT = 256;

	// divider: magnitude of (sample - min) * 255 fits in 24 bits
	localparam int DIVIDEND_W = 24;
	localparam int DIVISOR_W  = 16;
	localparam int DIV_STEPS  = DIVIDEND_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	// configuration registers
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MIN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MAX = 1'b1;
	localparam logic signed [SAMPLE_W-1:0] WINDOW_MIN_RST = 16'sh8000;
	localparam logic signed [SAMPLE_W-1:0] WINDOW_MAX_RST = 16'sh7fff;

	// command carried in tuser
	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DIV_INIT,
		ST_DIV,
		ST_LOOKUP,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic prep;
		logic div_init;
		logic div_step;
		logic mem_rd;
		logic mem_upd;
		logic clr;
		logic res_load;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_t kind;
		logic degenerate;
		logic div_last;
		logic out_free;
	} ctl_sts_t;

endpackage

// ----- hdl/pwh_ctrl.sv -----
// ----------------------------------------------------------------------------
// pwh_ctrl: sequencer of the window histogram unit
// Steps one item through dispatch, iterative divide, bin lookup, counter
// update and result hand-off.
// ----------------------------------------------------------------------------
module pwh_ctrl import pwh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ctl_sts_t  sts,
	output ctl_cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				unique case (sts.kind)
					CMD_SAMPLE: state_nxt = sts.degenerate ? ST_LOOKUP : ST_DIV_INIT;
					CMD_READ:   state_nxt = ST_LOOKUP;
					default:    state_nxt = ST_FINISH;
				endcase
			end
			ST_DIV_INIT: state_nxt = ST_DIV;
			ST_DIV: begin
				if (sts.div_last) state_nxt = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				state_nxt = (sts.kind == CMD_SAMPLE) ? ST_UPDATE : ST_FINISH;
			end
			ST_UPDATE: state_nxt = ST_FINISH;
			ST_FINISH: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DISPATCH: begin
				cmd.prep = 1'b1;
				cmd.clr  = (sts.kind == CMD_CLEAR);
			end
			ST_DIV_INIT: cmd.div_init = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_LOOKUP:   cmd.mem_rd   = 1'b1;
			ST_UPDATE:   cmd.mem_upd  = 1'b1;
			ST_FINISH:   cmd.res_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ----- hdl/pwh_datapath.sv -----
// ----------------------------------------------------------------------------
// pwh_datapath: arithmetic and storage of the window histogram unit
// Window registers, scaled-difference prep, radix-2 restoring divider,
// 256-entry counter memory with clear-all valid bits, and the output register.
// ----------------------------------------------------------------------------
module pwh_datapath import pwh_pkg::*; #(
	parameter int COUNTER_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration writes
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [SAMPLE_W-1:0]    cfg_data,
	// input beat payload
	input  logic [1:0]             in_user,
	input  logic [IN_TDATA_W-1:0]  in_data,
	// output beat
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data,
	// controller link
	input  ctl_cmd_t               cmd,
	output ctl_sts_t               sts
);

	localparam int BIN_AW = $clog2(BIN_COUNT);

	logic signed [SAMPLE_W-1:0] win_min_q;
	logic signed [SAMPLE_W-1:0] win_max_q;

	cmd_t                       kind_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [BIN_W-1:0]           bin_q;

	logic signed [SAMPLE_W:0]   diff;
	logic signed [SAMPLE_W+8:0] prod;
	logic signed [SAMPLE_W+8:0] prod_q;
	logic signed [SAMPLE_W:0]   den_q;
	logic [SAMPLE_W+8:0]        prod_neg;
	logic [SAMPLE_W:0]          den_neg;

	logic [DIVIDEND_W-1:0]      quo_q;
	logic [DIVISOR_W-1:0]       rem_q;
	logic [DIVISOR_W-1:0]       dmag_q;
	logic                       qneg_q;
	logic [DIV_CNT_W-1:0]       cnt_q;
	logic [DIVISOR_W:0]         trial;
	logic [DIVISOR_W:0]         trial_sub;
	logic                       trial_ge;

	logic [PIX_W-1:0]           q_neg8;
	logic [PIX_W-1:0]           pix;
	logic                       degenerate;

	logic [COUNTER_WIDTH-1:0]   mem [BIN_COUNT];
	logic [BIN_COUNT-1:0]       vld_q;
	logic                       vld_s2;
	logic [COUNTER_WIDTH-1:0]   rd_s2;
	logic [BIN_AW-1:0]          rd_addr;
	logic [BIN_AW-1:0]          addr_s2;
	logic [COUNTER_WIDTH-1:0]   cur;
	logic [COUNTER_WIDTH-1:0]   cur_inc;
	logic [63:0]                cur_wide;

	logic [PIX_W-1:0]           res_pix;
	logic [COUNT_OUT_W-1:0]     res_cnt;
	logic                       out_valid_q;
	logic [OUT_TDATA_W-1:0]     out_data_q;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_min_q <= WINDOW_MIN_RST;
			win_max_q <= WINDOW_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_MIN: win_min_q <= cfg_data;
				REG_WINDOW_MAX: win_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign degenerate = (win_min_q == win_max_q);

	// item latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= CMD_SAMPLE;
		end else if (cmd.load) begin
			kind_q <= cmd_t'(in_user);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= in_data[SAMPLE_W-1:0];
			bin_q    <= in_data[SAMPLE_W+BIN_W-1:SAMPLE_W];
		end
	end

	// scaled difference (s - min) * 255 and window span
	assign diff = {sample_q[SAMPLE_W-1], sample_q} - {win_min_q[SAMPLE_W-1], win_min_q};
	assign prod = {diff, 8'b0} - {{8{diff[SAMPLE_W]}}, diff};

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			prod_q <= prod;
			den_q  <= {win_max_q[SAMPLE_W-1], win_max_q} - {win_min_q[SAMPLE_W-1], win_min_q};
		end
	end

	assign prod_neg = -prod_q;
	assign den_neg  = -den_q;

	// restoring divider on magnitudes, one quotient bit per cycle
	assign trial     = {rem_q, quo_q[DIVIDEND_W-1]};
	assign trial_sub = trial - {1'b0, dmag_q};
	assign trial_ge  = (trial >= {1'b0, dmag_q});

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			quo_q  <= prod_q[SAMPLE_W+8] ? prod_neg[DIVIDEND_W-1:0] : prod_q[DIVIDEND_W-1:0];
			dmag_q <= den_q[SAMPLE_W] ? den_neg[DIVISOR_W-1:0] : den_q[DIVISOR_W-1:0];
			qneg_q <= prod_q[SAMPLE_W+8] ^ den_q[SAMPLE_W];
			rem_q  <= '0;
			cnt_q  <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// signed quotient low byte, or low byte of min for an empty window
	assign q_neg8 = -quo_q[PIX_W-1:0];
	assign pix    = degenerate ? win_min_q[PIX_W-1:0]
	                           : (qneg_q ? q_neg8 : quo_q[PIX_W-1:0]);

	// bin memory, read registered
	assign rd_addr = (kind_q == CMD_READ) ? bin_q : pix;

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rd_s2   <= mem[rd_addr];
			addr_s2 <= rd_addr;
		end
		if (cmd.mem_upd) begin
			mem[addr_s2] <= cur_inc;
		end
	end

	// per-bin valid bits, cleared at once by reset and by the clear command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s2 <= 1'b0;
		end else begin
			if (cmd.mem_rd) vld_s2 <= vld_q[rd_addr];
			if (cmd.clr) begin
				vld_q <= '0;
			end else if (cmd.mem_upd) begin
				vld_q[addr_s2] <= 1'b1;
			end
		end
	end

	// saturating increment
	assign cur      = vld_s2 ? rd_s2 : '0;
	assign cur_inc  = (&cur) ? cur : cur + 1'b1;
	assign cur_wide = 64'(cur);

	// result fields
	assign res_pix = (kind_q == CMD_SAMPLE) ? pix : '0;
	assign res_cnt = (kind_q == CMD_READ) ? cur_wide[COUNT_OUT_W-1:0] : '0;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) out_data_q <= {res_cnt, res_pix};
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// status
	assign sts.kind       = kind_q;
	assign sts.degenerate = degenerate;
	assign sts.div_last   = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign sts.out_free   = !out_valid_q || out_ready;

endmodule

// ----- hdl/pixel_window_to_8bit_histogram_unit.sv -----
// ----------------------------------------------------------------------------
// pixel_window_to_8bit_histogram_unit: window normalize with 256-bin histogram
// Maps signed 16-bit samples to 8 bits through the configured window and
// keeps a saturating count per 8-bit value; bins can be read and cleared.
// ----------------------------------------------------------------------------
// One beat in, one beat out. tuser selects the command: pixel sample, read
// bin or clear histogram. A pixel sample occupies the unit from acceptance
// to the next ready: the quotient (s - min) * 255 / (max - min) is formed by
// a restoring divider at one bit per cycle, then the bin is read and written
// back through the single-port counter memory. A sample with min equal to max
// and a bin read skip the divider; a clear or unused command skips the lookup
// too. The histogram is empty after reset with no clearing pass; clear acts
// at once through per-bin valid bits. The result sits in an output register,
// so a new beat is taken while the previous result waits. Window registers
// must be written by the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module pixel_window_to_8bit_histogram_unit import pwh_pkg::*; #(
	parameter int COUNTER_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [SAMPLE_W-1:0]    cfg_data,
	// input stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample[15:0], bin_index[23:16]
	input  logic [1:0]             s_axis_tuser,  // cmd[1:0]
	// output stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // pixel8[7:0], bin_count[39:8]
);

	ctl_cmd_t ctl_cmd;
	ctl_sts_t ctl_sts;

	// sequencer
	pwh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	// arithmetic and histogram storage
	pwh_datapath #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_user   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.cmd       (ctl_cmd),
		.sts       (ctl_sts)
	);

endmodule
